// ===== sv/aesprng_pkg.sv =====
// Package with AES-128 constants, types and round functions for the generator.
`timescale 1ns / 1ps
package aesprng_pkg;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] entropy_key_a_high;
        logic [63:0] entropy_key_a_low;
        logic [63:0] entropy_key_b_high;
        logic [63:0] entropy_key_b_low;
    } req_t;

    typedef struct packed {
        logic [63:0] random_word;
    } rsp_t;

    localparam block_t H_INIT   = {16{8'hA5}};
    localparam block_t BLK_IPAD = {16{8'h36}};
    localparam block_t BLK_OPAD = {16{8'h5C}};

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon_next(input logic [7:0] r);
        return xtime(r);
    endfunction

    // Byte i of a block sits in bits 127-8i down to 120-8i.
    function automatic block_t key_step(input block_t k, input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] t;
        block_t o;
        for (int i = 0; i < 4; i++) begin
            w[i] = k[127 - 32 * i -: 32];
        end
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        o = {w[0], w[1], w[2], w[3]};
        return o;
    endfunction

    function automatic block_t enc_round(input block_t s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        block_t o;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = SBOX[b[i + 4 * ((c + i) % 4)]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = t[i];
        end
        return o;
    endfunction

endpackage

// ===== sv/aesprng_stream_if.sv =====
// Valid/ready channel interfaces for the generator request and result.
`timescale 1ns / 1ps
interface aesprng_req_if;
    logic              valid;
    logic              ready;
    aesprng_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aesprng_rsp_if;
    logic              valid;
    logic              ready;
    aesprng_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/aes128_prng_generator.sv =====
// Top level of the AES-128 based random generator with one shared round unit.
//
//   channel   direction  payload
//   req       sink       mode, entropy_key_a_high/low, entropy_key_b_high/low
//   rsp       source     random_word
//
// Every AES-128 pass runs on the single round unit: a load state for the initial
// key add, ten rounds with the round key made alongside, and a done state to
// store the pass result. A seed runs three passes, a generate runs two plus an
// output state to post the word. Reset clears the generator state gen_reg to
// zero. The request side is not ready while a pass runs or while a result waits
// in the output register.
`timescale 1ns / 1ps
module aes128_prng_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    aesprng_req_if.sink          req,
    aesprng_rsp_if.source        rsp
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_DONE  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Pass codes: which AES run is underway.
    typedef enum logic [1:0] {
        P_SEED_A = 2'd0,
        P_SEED_B = 2'd1,
        P_OPAD   = 2'd2,
        P_IPAD   = 2'd3
    } pass_t;

    state_t                 state_reg, state_next;
    pass_t                  pass_reg, pass_next;
    logic [3:0]             rnd_reg, rnd_next;
    logic [7:0]             rc_reg, rc_next;
    aesprng_pkg::block_t    gen_reg, gen_next;
    aesprng_pkg::block_t    h_reg, h_next;
    aesprng_pkg::block_t    kb_reg, kb_next;
    aesprng_pkg::block_t    key_reg, key_next;
    aesprng_pkg::block_t    s_reg, s_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_reg, out_next;
    aesprng_pkg::block_t    pass_key, pass_pt, rk;

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data.random_word = out_reg;

    assign rk = aesprng_pkg::key_step(key_reg, rc_reg);

    always_comb
    begin
        unique case (pass_reg)
            P_SEED_A: begin pass_key = key_reg; pass_pt = aesprng_pkg::H_INIT; end
            P_SEED_B: begin pass_key = kb_reg;  pass_pt = h_reg; end
            P_OPAD:   begin pass_key = gen_reg; pass_pt = aesprng_pkg::BLK_OPAD; end
            P_IPAD:   begin pass_key = gen_reg; pass_pt = aesprng_pkg::BLK_IPAD; end
            default:  begin pass_key = gen_reg; pass_pt = aesprng_pkg::BLK_IPAD; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        rnd_next       = rnd_reg;
        rc_next        = rc_reg;
        gen_next       = gen_reg;
        h_next         = h_reg;
        kb_next        = kb_reg;
        key_next       = key_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && rsp.ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (req.valid && req.ready) begin
                    if (!req.data.mode) begin
                        pass_next = P_SEED_A;
                        key_next  = {req.data.entropy_key_a_high, req.data.entropy_key_a_low};
                        kb_next   = {req.data.entropy_key_b_high, req.data.entropy_key_b_low};
                        h_next    = aesprng_pkg::H_INIT;
                    end else begin
                        pass_next = P_OPAD;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                key_next   = pass_key;
                s_next     = pass_pt ^ pass_key;
                rnd_next   = 4'd1;
                rc_next    = 8'h01;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                s_next   = aesprng_pkg::enc_round(s_reg, rnd_reg == 4'd10) ^ rk;
                key_next = rk;
                rc_next  = aesprng_pkg::rcon_next(rc_reg);
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd10) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_LOAD;
                unique case (pass_reg)
                    P_SEED_A: begin
                        h_next    = s_reg ^ h_reg;
                        pass_next = P_SEED_B;
                    end
                    P_SEED_B: begin
                        gen_next  = s_reg ^ h_reg;
                        pass_next = P_IPAD;
                    end
                    P_OPAD: begin
                        out_next  = s_reg[127:64];
                        pass_next = P_IPAD;
                    end
                    P_IPAD: begin
                        gen_next   = s_reg;
                        state_next = ST_IDLE;
                    end
                    default: state_next = ST_IDLE;
                endcase
                if (pass_reg == P_OPAD) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                out_valid_next = 1'b1;
                state_next     = ST_LOAD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pass_reg      <= P_SEED_A;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        rc_reg  <= rc_next;
        h_reg   <= h_next;
        kb_reg  <= kb_next;
        key_reg <= key_next;
        s_reg   <= s_next;
        out_reg <= out_next;
    end

endmodule
